/* src/ppls_pkg.sv */
// Shared types and codes for the pump purge level sequencer.
package ppls_pkg;

  // Default number of fraction bits of the level factor.
  localparam int unsigned FracBitsDef = 16;

  // Width of the unscaled product of difference and factor.
  localparam int unsigned ProdW = 48;

  // Action codes carried by an input word.
  localparam logic [1:0] ActTick  = 2'd0;
  localparam logic [1:0] ActStart = 2'd1;
  localparam logic [1:0] ActLock  = 2'd2;
  localparam logic [1:0] ActRead  = 2'd3;

  // Measurement phase codes.
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhReq  = 2'd1;
  localparam logic [1:0] PhBusy = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] RegRaiseTicks = 2'd0;
  localparam logic [1:0] RegHoldTicks  = 2'd1;
  localparam logic [1:0] RegOffset     = 2'd2;
  localparam logic [1:0] RegFactor     = 2'd3;

  // Input word.
  typedef struct packed {
    logic [1:0]  action;
    logic        lock_value;
    logic        lock_pin;
    logic [15:0] sample_mv;
    logic [31:0] now_time;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic        pump_on;
    logic        busy_res;
    logic [15:0] level;
    logic [31:0] level_time;
  } out_word_t;

  // Configuration write word.
  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
  } cfg_word_t;

endpackage

/* src/ppls_chan_if.sv */
// Valid/ready channel interface used for input, result and configuration words.
interface ppls_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/pump_purge_level_sequencer.sv */
// Top level of the pump purge level sequencer.

// The sequencer takes one input word per clock cycle while in_i.ready is high
// and returns one result word per input word. The word sits in an input
// register, where the phase, counters and captures are updated; the clamped
// sample difference then goes through a registered 16 x 32 multiplier, and the
// saturated level is placed in the output register. Input and output stall
// through per-stage valid bits, so bubbles are squeezed out and a new word is
// taken while a result waits. Configuration writes complete in the cycle they
// are offered and must only be issued while no word is in flight.
module pump_purge_level_sequencer #(
  parameter int unsigned FracBits = ppls_pkg::FracBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppls_chan_if.sink   in_i,
  ppls_chan_if.source out_o,
  ppls_chan_if.sink   cfg_i
);
  import ppls_pkg::*;

  // Configuration registers.
  logic [15:0] raise_ticks_q, hold_ticks_q, offset_q;
  logic [31:0] factor_q;

  // Sequencer state.
  logic [1:0]  phase_q, phase_d;
  logic        soft_lock_q, soft_lock_d;
  logic [15:0] raise_cnt_q, raise_cnt_d;
  logic [15:0] hold_cnt_q, hold_cnt_d;
  logic        pump_q, pump_d;
  logic [15:0] cap_sample_q, cap_sample_d;
  logic [31:0] cap_time_q, cap_time_d;
  logic [31:0] read_time_q, read_time_d;

  // Pipeline stages.
  logic        e_vld_q, m_vld_q, p_vld_q, o_vld_q;
  in_word_t    e_data_q;
  logic        m_pump_q, m_busy_q, p_pump_q, p_busy_q;
  logic [31:0] m_time_q, p_time_q;
  logic [15:0] m_diff_q, m_diff_d;
  logic [ProdW-1:0] p_prod_q;
  out_word_t   o_data_q, o_data_d;

  logic o_adv, p_adv, m_adv, e_adv, e_fire;

  // Stage advance: a stage loads when empty or when its content moves on.
  assign o_adv  = !o_vld_q || out_o.ready;
  assign p_adv  = !p_vld_q || o_adv;
  assign m_adv  = !m_vld_q || p_adv;
  assign e_adv  = !e_vld_q || m_adv;
  assign e_fire = e_vld_q && m_adv;

  assign in_i.ready  = e_adv;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = o_vld_q;
  assign out_o.data  = o_data_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raise_ticks_q <= '0;
      hold_ticks_q  <= '0;
      offset_q      <= '0;
      factor_q      <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        RegRaiseTicks: raise_ticks_q <= cfg_i.data.value[15:0];
        RegHoldTicks:  hold_ticks_q  <= cfg_i.data.value[15:0];
        RegOffset:     offset_q      <= cfg_i.data.value[15:0];
        RegFactor:     factor_q      <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // Action decode and state update for the word in the input register.
  always_comb begin
    phase_d      = phase_q;
    soft_lock_d  = soft_lock_q;
    raise_cnt_d  = raise_cnt_q;
    hold_cnt_d   = hold_cnt_q;
    pump_d       = pump_q;
    cap_sample_d = cap_sample_q;
    cap_time_d   = cap_time_q;
    read_time_d  = read_time_q;
    m_diff_d     = '0;
    unique case (e_data_q.action)
      ActTick: begin
        if (phase_q == PhReq) begin
          raise_cnt_d = raise_ticks_q;
          hold_cnt_d  = hold_ticks_q;
          if (!soft_lock_q && !e_data_q.lock_pin) begin
            pump_d  = 1'b1;
            phase_d = PhBusy;
          end
        end else if (phase_q == PhBusy) begin
          if (raise_cnt_q != '0) begin
            raise_cnt_d = raise_cnt_q - 16'd1;
          end else begin
            pump_d = 1'b0;
            if (hold_cnt_q != '0) begin
              hold_cnt_d = hold_cnt_q - 16'd1;
            end else begin
              cap_sample_d = e_data_q.sample_mv;
              cap_time_d   = e_data_q.now_time;
              phase_d      = PhIdle;
            end
          end
        end else begin
          // The unused phase code falls back to idle on a tick.
          phase_d = PhIdle;
        end
      end
      ActStart: begin
        if (phase_q == PhIdle) begin
          phase_d = PhReq;
        end
      end
      ActLock: begin
        soft_lock_d = e_data_q.lock_value;
      end
      ActRead: begin
        read_time_d = cap_time_q;
        // A sample below the offset clamps the difference to zero.
        if (cap_sample_q >= offset_q) begin
          m_diff_d = cap_sample_q - offset_q;
        end
      end
      default: ;
    endcase
  end

  // Sequencer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      soft_lock_q  <= 1'b0;
      raise_cnt_q  <= '0;
      hold_cnt_q   <= '0;
      pump_q       <= 1'b0;
      cap_sample_q <= '0;
      cap_time_q   <= '0;
      read_time_q  <= '0;
    end else if (e_fire) begin
      phase_q      <= phase_d;
      soft_lock_q  <= soft_lock_d;
      raise_cnt_q  <= raise_cnt_d;
      hold_cnt_q   <= hold_cnt_d;
      pump_q       <= pump_d;
      cap_sample_q <= cap_sample_d;
      cap_time_q   <= cap_time_d;
      read_time_q  <= read_time_d;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (e_adv) begin
        e_vld_q <= in_i.valid;
      end
      if (m_adv) begin
        m_vld_q <= e_vld_q;
      end
      if (p_adv) begin
        p_vld_q <= m_vld_q;
      end
      if (o_adv) begin
        o_vld_q <= p_vld_q;
      end
    end
  end

  // Saturate the scaled product into the result word.
  always_comb begin
    o_data_d.pump_on    = p_pump_q;
    o_data_d.busy_res   = p_busy_q;
    o_data_d.level_time = p_time_q;
    if (|p_prod_q[ProdW-1:FracBits+16]) begin
      o_data_d.level = 16'hFFFF;
    end else begin
      o_data_d.level = p_prod_q[FracBits +: 16];
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (e_adv && in_i.valid) begin
      e_data_q <= in_i.data;
    end
    if (e_fire) begin
      m_pump_q <= pump_d;
      m_busy_q <= (phase_d != PhIdle);
      m_time_q <= read_time_d;
      m_diff_q <= m_diff_d;
    end
    if (p_adv && m_vld_q) begin
      p_pump_q <= m_pump_q;
      p_busy_q <= m_busy_q;
      p_time_q <= m_time_q;
      p_prod_q <= {32'd0, m_diff_q} * {16'd0, factor_q};
    end
    if (o_adv && p_vld_q) begin
      o_data_q <= o_data_d;
    end
  end

  // The pump only runs during the busy phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pump_q |-> (phase_q == PhBusy))
    else $error("pump driven outside the busy phase");

  // Input is refused only when every stage is occupied and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (e_vld_q && m_vld_q && p_vld_q && o_vld_q && !out_o.ready))
    else $error("input refused while the pipeline has room");

  // A result with the pump running also reports a busy measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && o_data_q.pump_on) |-> o_data_q.busy_res)
    else $error("pump reported on while not busy");

endmodule

/* dv/pump_purge_level_sequencer_test.sv */
// Self-checking testbench for the pump purge level sequencer.
`timescale 1ns / 100ps

module pump_purge_level_sequencer_test;
  import ppls_pkg::*;

  localparam int unsigned FracBits = FracBitsDef;
  // Cycles allowed after the last result word before configuration or the end.
  localparam int unsigned DrainCycles = 8;
  // Cycles without any accepted word before the run is abandoned.
  localparam int unsigned IdleLimit = 2000;

  typedef enum logic [1:0] {SinkOpen, SinkCoin, SinkPeriodic, SinkBursty} sink_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ppls_chan_if #(.payload_t(in_word_t))  in_ch ();
  ppls_chan_if #(.payload_t(out_word_t)) out_ch ();
  ppls_chan_if #(.payload_t(cfg_word_t)) cfg_ch ();

  pump_purge_level_sequencer #(
    .FracBits(FracBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the sequencer registers and state.
  logic [15:0] cfg_raise   = '0;
  logic [15:0] cfg_hold    = '0;
  logic [15:0] cfg_offset  = '0;
  logic [31:0] cfg_factor  = '0;
  logic [1:0]  seq_phase   = PhIdle;
  logic        sw_lock     = 1'b0;
  logic [15:0] raise_left  = '0;
  logic [15:0] hold_left   = '0;
  logic        pump_state  = 1'b0;
  logic [15:0] held_sample = '0;
  logic [31:0] held_time   = '0;
  logic [31:0] shown_time  = '0;

  out_word_t   pending_results[$];
  int unsigned fail_count  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;

  // Advances the shadow state by one input word and returns the result word it yields.
  function automatic out_word_t next_result(in_word_t w);
    out_word_t   res;
    logic [15:0] lvl;
    logic [15:0] diff;
    logic [47:0] prod;
    lvl = '0;
    case (w.action)
      ActTick: begin
        if (seq_phase == PhReq) begin
          // The request tick reloads both counters even when locked.
          raise_left = cfg_raise;
          hold_left  = cfg_hold;
          if (!sw_lock && !w.lock_pin) begin
            pump_state = 1'b1;
            seq_phase  = PhBusy;
          end
        end else if (seq_phase == PhBusy) begin
          if (raise_left != 0) begin
            raise_left = raise_left - 16'd1;
          end else begin
            pump_state = 1'b0;
            if (hold_left != 0) begin
              hold_left = hold_left - 16'd1;
            end else begin
              held_time   = w.now_time;
              held_sample = w.sample_mv;
              seq_phase   = PhIdle;
            end
          end
        end else begin
          // An unused phase code falls back to idle.
          seq_phase = PhIdle;
        end
      end
      ActStart: begin
        if (seq_phase == PhIdle) begin
          seq_phase = PhReq;
        end
      end
      ActLock: begin
        sw_lock = w.lock_value;
      end
      default: begin
        // Read: offset removal clamped at zero, fixed-point scaling, saturation.
        shown_time = held_time;
        if (held_sample >= cfg_offset) begin
          diff = held_sample - cfg_offset;
          prod = (48'(diff) * 48'(cfg_factor)) >> FracBits;
          lvl  = (prod > 48'hFFFF) ? 16'hFFFF : prod[15:0];
        end
      end
    endcase
    res.pump_on    = pump_state;
    res.busy_res   = (seq_phase != PhIdle);
    res.level      = lvl;
    res.level_time = shown_time;
    return res;
  endfunction

  function automatic in_word_t pack_word(logic [1:0] act, logic lockv, logic pin,
                                         logic [15:0] smp, logic [31:0] stamp);
    in_word_t w;
    w.action     = act;
    w.lock_value = lockv;
    w.lock_pin   = pin;
    w.sample_mv  = smp;
    w.now_time   = stamp;
    return w;
  endfunction

  // Random fields, with samples often placed around the current offset.
  function automatic in_word_t random_word(logic [1:0] act);
    in_word_t w;
    w.action     = act;
    w.lock_value = 1'($urandom_range(0, 1));
    w.lock_pin   = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       w.sample_mv = cfg_offset + 16'($urandom_range(0, 255));
      1:       w.sample_mv = 16'($urandom_range(0, cfg_offset));
      default: w.sample_mv = 16'($urandom);
    endcase
    w.now_time = $urandom;
    return w;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  // Sends one input word in bursts with random gaps and records its expected result.
  task automatic send_word(in_word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    pending_results.push_back(next_result(w));
  endtask

  // Holds the sender off until every expected result word has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_word_t c;
    c.index = idx;
    c.value = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    case (idx)
      RegRaiseTicks: cfg_raise  = val[15:0];
      RegHoldTicks:  cfg_hold   = val[15:0];
      RegOffset:     cfg_offset = val[15:0];
      default:       cfg_factor = val;
    endcase
  endtask

  // Writes all four registers once the pipeline is empty.
  task automatic set_config(logic [15:0] raise, logic [15:0] hold, logic [15:0] offset,
                            logic [31:0] factor);
    wait_drained();
    write_reg(RegRaiseTicks, 32'(raise));
    write_reg(RegHoldTicks, 32'(hold));
    write_reg(RegOffset, 32'(offset));
    write_reg(RegFactor, factor);
    cfg_ch.valid <= 1'b0;
  endtask

  // Reads and ticks while idle, before anything was captured.
  task automatic test_idle_actions();
    send_word(pack_word(ActRead, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(pack_word(ActTick, 1'b0, 1'b0, 16'h0000, 32'h0000_0000));
  endtask

  // Software lock and lock pin hold a request; a start while requested is ignored.
  task automatic test_lock_paths();
    send_word(pack_word(ActLock, 1'b1, 1'b0, 16'h1234, 32'h1));
    send_word(pack_word(ActStart, 1'b0, 1'b0, 16'h0, 32'h2));
    send_word(pack_word(ActTick, 1'b0, 1'b0, 16'h0, 32'h3));
    send_word(pack_word(ActStart, 1'b1, 1'b1, 16'h0, 32'h4));
    send_word(pack_word(ActLock, 1'b0, 1'b1, 16'h0, 32'h5));
    send_word(pack_word(ActTick, 1'b0, 1'b1, 16'h0, 32'h6));
    send_word(pack_word(ActTick, 1'b0, 1'b0, 16'h0, 32'h7));
    send_word(pack_word(ActTick, 1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(pack_word(ActRead, 1'b0, 1'b0, 16'h0, 32'h0));
  endtask

  // A sample below the offset reads as zero; a full-scale one saturates.
  task automatic test_offset_and_saturation();
    logic [15:0] samples[2];
    in_word_t    w;
    samples = '{16'd50, 16'hFFFF};
    set_config(16'd1, 16'd1, 16'd100, 32'hFFFF_FFFF);
    foreach (samples[i]) begin
      send_word(pack_word(ActStart, 1'b0, 1'b0, 16'h0, $urandom));
      while (seq_phase != PhIdle) begin
        w = random_word(ActTick);
        w.lock_pin  = 1'b0;
        w.sample_mv = samples[i];
        send_word(w);
      end
      send_word(random_word(ActRead));
    end
  endtask

  // Random measurement sequences and noise under a series of register settings.
  task automatic test_random_phases();
    int unsigned sent;
    int unsigned ticks;
    int unsigned budget;
    logic [31:0] factor;
    in_word_t    w;
    for (int p = 0; p < 12; p++) begin
      factor = $urandom;
      case ($urandom_range(0, 2))
        0:       factor = $urandom_range(0, 32'h0003_0000);
        1:       factor = $urandom_range(0, 32'h0000_0400);
        default: ;
      endcase
      // The first setting has zero counts and offset with a unit factor; the last runs the counters from their top.
      if (p == 0) begin
        set_config(16'd0, 16'd0, 16'd0, 32'h0001_0000);
      end else if (p == 11) begin
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      end else begin
        set_config(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)),
                   factor);
      end
      budget = (p == 11) ? 60 : 115;
      sent = 0;
      while (sent < budget) begin
        if ($urandom_range(0, 9) < 7) begin
          // Well-formed measurement: optional lock write, start, ticks to the end, read.
          if ($urandom_range(0, 3) == 0) begin
            w = random_word(ActLock);
            w.lock_value = ($urandom_range(0, 3) == 0);
            send_word(w);
            sent++;
          end
          send_word(random_word(ActStart));
          sent++;
          ticks = 0;
          while (seq_phase != PhIdle && ticks < 48) begin
            case ($urandom_range(0, 11))
              0: w = random_word(ActRead);
              1: w = random_word(ActStart);
              2: begin
                w = random_word(ActLock);
                w.lock_value = 1'b0;
              end
              default: begin
                w = random_word(ActTick);
                w.lock_pin = ($urandom_range(0, 7) == 0);
              end
            endcase
            send_word(w);
            sent++;
            ticks++;
          end
          send_word(random_word(ActRead));
          sent++;
        end else begin
          send_word(random_word(2'($urandom_range(0, 3))));
          sent++;
        end
        if ($urandom_range(0, 199) == 0) begin
          wait_drained();
        end
      end
    end
  endtask

  // Result checker: each accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result word 0x%0h arrived with no expected word pending", got);
      end else begin
        want = pending_results.pop_front();
        check_field("pump_on", 32'(want.pump_on), 32'(got.pump_on));
        check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
        check_field("level", 32'(want.level), 32'(got.level));
        check_field("level_time", want.level_time, got.level_time);
      end
    end
  end

  // Receiver back-pressure, switching between several stall patterns.
  sink_mode_e  sink_mode       = SinkOpen;
  int unsigned sink_mode_left  = 0;
  int unsigned sink_stall_left = 0;
  int unsigned sink_cycle      = 0;

  always @(posedge clk_i) begin
    sink_cycle++;
    if (sink_mode_left == 0) begin
      sink_mode      = sink_mode_e'($urandom_range(0, 3));
      sink_mode_left = $urandom_range(50, 300);
    end else begin
      sink_mode_left--;
    end
    case (sink_mode)
      SinkOpen:     out_ch.ready <= 1'b1;
      SinkCoin:     out_ch.ready <= 1'($urandom_range(0, 1));
      SinkPeriodic: out_ch.ready <= (sink_cycle % 5) < 2;
      default: begin
        if (sink_stall_left != 0) begin
          sink_stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) begin
            sink_stall_left = $urandom_range(5, 30);
          end
        end
      end
    endcase
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("pump_purge_level_sequencer_test: FAIL");
      $finish;
    end
  end

  // Reset, the tests in turn, then the verdict.
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_actions();
    test_lock_paths();
    test_offset_and_saturation();
    test_random_phases();
    wait_drained();
    if (fail_count == 0) begin
      $display("pump_purge_level_sequencer_test: PASS");
    end else begin
      $display("pump_purge_level_sequencer_test: FAIL");
    end
    $finish;
  end

endmodule
